// ----- src/ncmm_pkg.sv -----
// Shared types and constants of the named channel mailbox.
package ncmm_pkg;

  localparam int Channels     = 16;
  localparam int QueueDepth   = 16;
  localparam int MessageBytes = 64;
  localparam int NameChars    = 8;

  localparam int ChW   = $clog2(Channels);
  localparam int QW    = $clog2(QueueDepth);
  localparam int SlotW = ChW + QW;
  localparam int BW    = $clog2(MessageBytes);
  localparam int LenW  = BW + 1;
  localparam int CntW  = $clog2(QueueDepth + 1);
  localparam int TotW  = $clog2(Channels + 1);

  localparam logic [2:0] ModeCreate = 3'd0;
  localparam logic [2:0] ModeFind   = 3'd1;
  localparam logic [2:0] ModeSend   = 3'd2;
  localparam logic [2:0] ModeRecv   = 3'd3;
  localparam logic [2:0] ModeCount  = 3'd4;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StBadArg   = 3'd1;
  localparam logic [2:0] StBadChan  = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StEmpty    = 3'd4;
  localparam logic [2:0] StSmall    = 3'd5;
  localparam logic [2:0] StNoSlot   = 3'd6;
  localparam logic [2:0] StNotFound = 3'd7;

  // Command from controller to datapath.
  typedef struct packed {
    logic load;      // capture the request
    logic scan_step; // compare one channel key
    logic send_exec; // perform the send byte and commit
    logic create_do; // claim the channel found by the scan
    logic rd_start;  // issue read of length and sender
    logic rd_step;   // advance the payload read pointer
    logic rd_pop;    // pop the head message
    logic copy_step; // move one assembled byte toward its queue slot
  } ncmm_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic scan_done;
    logic rd_last;
    logic send_commit;
    logic copy_last;
  } ncmm_sts_t;

endpackage

// ----- src/named_channel_message_mailbox.sv -----
// Top level of the named channel mailbox.
// A request passes a scan state, which compares every channel key for create and find,
// and a decide state that offers the result; a receive then reads its head slot and
// streams one byte per cycle while the output is free. One request is handled at a time,
// and a committing send then copies the message byte by byte into its queue slot.
// Reset clears the channel table, counters and send assembly; memories are not cleared.
module named_channel_message_mailbox import ncmm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: mode, name_key, chan_sel, data_byte, sender_id, task_now,
  // receive_capacity, zero fill
  input  logic [231:0] s_axis_tdata,
  input  logic         s_axis_tlast,   // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: status, found_channel, out_byte, message_length, message_sender,
  // open_count, zero fill
  output logic [95:0]  m_axis_tdata,
  output logic         m_axis_tlast    // final_result
);
  ncmm_cmd_t cmd;
  ncmm_sts_t sts;
  logic emit, recv_ok, res_free, out_v_q;
  logic [2:0] status;
  logic [3:0] fch;
  logic [7:0] ob;
  logic [6:0] ml;
  logic [63:0] ms;
  logic [4:0] oc;
  logic fin;

  assign res_free = !out_v_q || m_axis_tready;

  ncmm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .mode_i(s_axis_tdata[2:0]), .res_free_i(res_free),
    .sts_i(sts), .recv_ok_i(recv_ok), .cmd_o(cmd), .emit_o(emit)
  );

  ncmm_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .emit_i(emit),
    .mode_i(s_axis_tdata[2:0]), .name_key_i(s_axis_tdata[66:3]),
    .chan_sel_i(s_axis_tdata[74:67]), .data_byte_i(s_axis_tdata[82:75]),
    .last_byte_i(s_axis_tlast), .sender_id_i(s_axis_tdata[146:83]),
    .task_now_i(s_axis_tdata[210:147]), .receive_capacity_i(s_axis_tdata[226:211]),
    .sts_o(sts), .recv_ok_o(recv_ok), .status_o(status), .found_channel_o(fch),
    .out_byte_o(ob), .message_length_o(ml), .message_sender_o(ms),
    .open_count_o(oc), .final_o(fin)
  );

  // Output valid register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (emit) out_v_q <= 1'b1;
    else if (m_axis_tready) out_v_q <= 1'b0;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {5'd0, oc, ms, ml, ob, fch, status};
  assign m_axis_tlast = fin;
endmodule

// ----- src/ncmm_ctrl.sv -----
// Controller state machine of the named channel mailbox.
module ncmm_ctrl import ncmm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [2:0] mode_i,
  input  logic      res_free_i,
  input  ncmm_sts_t sts_i,
  input  logic      recv_ok_i,
  output ncmm_cmd_t cmd_o,
  output logic      emit_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_RDA, S_RDB, S_STREAM, S_COPY
  } state_e;

  state_e state_q, state_d;
  logic [2:0] mode_q;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    emit_o = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (mode_q == ModeCreate || mode_q == ModeFind) begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.scan_done) state_d = S_DECIDE;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (mode_q == ModeRecv) begin
          if (recv_ok_i) begin
            cmd_o.rd_start = 1'b1;
            state_d = S_RDA;
          end else if (res_free_i) begin
            emit_o = 1'b1;
            state_d = S_IDLE;
          end
        end else if (res_free_i) begin
          emit_o = 1'b1;
          cmd_o.send_exec = (mode_q == ModeSend);
          cmd_o.create_do = (mode_q == ModeCreate);
          state_d = (mode_q == ModeSend && sts_i.send_commit) ? S_COPY : S_IDLE;
        end
      end
      S_RDA: state_d = S_RDB;
      S_RDB: begin
        cmd_o.rd_pop = 1'b1;
        state_d = S_STREAM;
      end
      S_STREAM: begin
        if (res_free_i) begin
          emit_o = 1'b1;
          cmd_o.rd_step = 1'b1;
          if (sts_i.rd_last) state_d = S_IDLE;
        end
      end
      // A committed message is moved into its queue slot one byte per cycle.
      S_COPY: begin
        cmd_o.copy_step = 1'b1;
        if (sts_i.copy_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q <= ModeCreate;
    end else begin
      state_q <= state_d;
      if (cmd_o.load) mode_q <= mode_i;
    end
  end
endmodule

// ----- src/ncmm_datapath.sv -----
// Datapath of the named channel mailbox: channel table, queues and memories.
module ncmm_datapath import ncmm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ncmm_cmd_t   cmd_i,
  input  logic        emit_i,
  input  logic [2:0]  mode_i,
  input  logic [63:0] name_key_i,
  input  logic [7:0]  chan_sel_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [63:0] sender_id_i,
  input  logic [63:0] task_now_i,
  input  logic [15:0] receive_capacity_i,
  output ncmm_sts_t   sts_o,
  output logic        recv_ok_o,
  output logic [2:0]  status_o,
  output logic [3:0]  found_channel_o,
  output logic [7:0]  out_byte_o,
  output logic [6:0]  message_length_o,
  output logic [63:0] message_sender_o,
  output logic [4:0]  open_count_o,
  output logic        final_o
);
  // Request registers.
  logic [2:0]  mode_q;
  logic [63:0] key_q;
  logic [3:0]  nlen_q;
  logic [7:0]  id_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [63:0] snd_q;
  logic [15:0] cap_q;

  // Channel table.
  logic [Channels-1:0] used_q;
  logic [63:0]         ckey_q [Channels];
  logic [QW-1:0]       rslot_q [Channels];
  logic [QW-1:0]       wslot_q [Channels];
  logic [CntW-1:0]     qcnt_q [Channels];
  logic [TotW-1:0]     total_q;

  // Send assembly.
  logic [LenW-1:0] alen_q;
  logic            aovf_q;

  // Scan state.
  logic [ChW:0]   scan_q;
  logic           hit_q, free_ok_q;
  logic [ChW-1:0] hit_ch_q, free_ch_q;

  // Memories.
  logic [7:0]       pay_mem [Channels*QueueDepth*MessageBytes];
  logic [LenW-1:0]  len_mem [Channels*QueueDepth];
  logic [63:0]      snd_mem [Channels*QueueDepth];
  logic [7:0]       asm_mem [MessageBytes];
  logic [LenW-1:0]  len_rd_q;
  logic [63:0]      snd_rd_q;
  logic [7:0]       pay_rd_q;

  // Copy of a committed message from the assembly into its queue slot.
  logic [SlotW-1:0] cp_slot_q;
  logic [LenW-1:0]  cp_len_q;
  logic [BW-1:0]    cp_rd_q, cp_wr_q;
  logic             cp_wr_v_q;
  logic [7:0]       asm_rd_q;

  // Receive streaming.
  logic [SlotW-1:0] rslot_sel_q;
  logic [BW-1:0]    rptr_q;
  logic             streaming_q;

  // Result register.
  logic [2:0]  st_q;
  logic [3:0]  fc_q;

  // Name normalization of the incoming key.
  logic [63:0] nkey;
  logic [3:0]  nlen;
  logic        zero_seen;
  always_comb begin
    nkey = '0;
    nlen = '0;
    zero_seen = 1'b0;
    for (int n = 0; n < 8; n++) begin
      if (name_key_i[8*n +: 8] == 8'd0) zero_seen = 1'b1;
      if (!zero_seen) begin
        nkey[8*n +: 8] = name_key_i[8*n +: 8];
        nlen = 4'(n + 1);
      end
    end
  end

  // Channel validity of the addressed id.
  logic            id_in;
  logic [ChW-1:0]  idc;
  logic            id_valid;
  assign id_in    = (id_q < 8'(Channels));
  assign idc      = id_q[ChW-1:0];
  assign id_valid = id_in && used_q[idc];

  logic [SlotW-1:0] wr_slot, rd_slot;
  assign wr_slot = {idc, wslot_q[idc]};
  assign rd_slot = {idc, rslot_q[idc]};

  logic [ChW-1:0] sc;
  assign sc = scan_q[ChW-1:0];
  assign sts_o.scan_done = (scan_q == (ChW+1)'(Channels - 1));
  assign sts_o.rd_last   = ({1'b0, rptr_q} + 1'b1 == len_rd_q);
  assign sts_o.copy_last = ({1'b0, cp_rd_q} + 1'b1 == cp_len_q);

  // Receive checks rely on the length already read at the head slot.
  logic [LenW-1:0] head_len_q;
  assign recv_ok_o = id_valid && (qcnt_q[idc] != '0) && (cap_q >= 16'(head_len_q));

  // Send decision computed at execution.
  logic [LenW-1:0] alen_n;
  logic            aovf_n;
  logic [2:0]      send_st;
  logic            commit;
  always_comb begin
    alen_n = alen_q;
    aovf_n = aovf_q;
    if (alen_q < LenW'(MessageBytes)) alen_n = alen_q + 1'b1;
    else aovf_n = 1'b1;
    send_st = StOk;
    commit = 1'b0;
    if (last_q) begin
      if (aovf_n) send_st = StBadArg;
      else if (!id_valid) send_st = StBadChan;
      else if (qcnt_q[idc] >= CntW'(QueueDepth)) send_st = StFull;
      else commit = 1'b1;
    end
  end
  assign sts_o.send_commit = commit;

  // Single-result status for non-streaming modes.
  logic [2:0] res_st;
  logic [3:0] res_fc;
  logic       name_bad;
  assign name_bad = (nlen_q == 4'd0) || (nlen_q > 4'(NameChars));
  always_comb begin
    res_st = StBadArg;
    res_fc = '0;
    case (mode_q)
      ModeCreate: begin
        if (name_bad) res_st = StBadArg;
        else if (hit_q) begin res_st = StOk; res_fc = 4'(hit_ch_q); end
        else if (free_ok_q) begin res_st = StOk; res_fc = 4'(free_ch_q); end
        else res_st = StNoSlot;
      end
      ModeFind: begin
        if (hit_q && nlen_q != 4'd0) begin res_st = StOk; res_fc = 4'(hit_ch_q); end
        else res_st = StNotFound;
      end
      ModeSend:  res_st = send_st;
      ModeRecv: begin
        if (!id_valid) res_st = StBadChan;
        else if (qcnt_q[idc] == '0) res_st = StEmpty;
        else res_st = StSmall;
      end
      ModeCount: res_st = StOk;
      default:   res_st = StBadArg;
    endcase
  end

  logic do_create;
  assign do_create = cmd_i.create_do && !name_bad && !hit_q && free_ok_q;

  // Request capture, scan and assembly control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      total_q <= '0;
      alen_q <= '0;
      aovf_q <= 1'b0;
      scan_q <= '0;
      hit_q <= 1'b0;
      free_ok_q <= 1'b0;
      hit_ch_q <= '0;
      free_ch_q <= '0;
      streaming_q <= 1'b0;
      cp_wr_v_q <= 1'b0;
      final_o <= 1'b0;
      for (int i = 0; i < Channels; i++) begin
        ckey_q[i] <= '0;
        rslot_q[i] <= '0;
        wslot_q[i] <= '0;
        qcnt_q[i] <= '0;
      end
    end else begin
      cp_wr_v_q <= cmd_i.copy_step;
      if (cmd_i.load) begin
        scan_q <= '0;
        hit_q <= 1'b0;
        free_ok_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        scan_q <= scan_q + 1'b1;
        if (used_q[sc] && ckey_q[sc] == key_q && !hit_q) begin
          hit_q <= 1'b1;
          hit_ch_q <= sc;
        end
        if (!used_q[sc] && !free_ok_q) begin
          free_ok_q <= 1'b1;
          free_ch_q <= sc;
        end
      end
      if (cmd_i.send_exec) begin
        if (last_q) begin
          alen_q <= '0;
          aovf_q <= 1'b0;
        end else begin
          alen_q <= alen_n;
          aovf_q <= aovf_n;
        end
        if (commit) begin
          wslot_q[idc] <= wslot_q[idc] + 1'b1;
          qcnt_q[idc] <= qcnt_q[idc] + 1'b1;
        end
      end
      if (do_create) begin
        used_q[free_ch_q] <= 1'b1;
        ckey_q[free_ch_q] <= key_q;
        rslot_q[free_ch_q] <= '0;
        wslot_q[free_ch_q] <= '0;
        qcnt_q[free_ch_q] <= '0;
        total_q <= total_q + 1'b1;
      end
      if (cmd_i.rd_pop) begin
        rslot_q[idc] <= rslot_q[idc] + 1'b1;
        qcnt_q[idc] <= qcnt_q[idc] - 1'b1;
        streaming_q <= 1'b1;
      end
      if (emit_i) begin
        final_o <= !streaming_q || sts_o.rd_last;
        if (streaming_q && sts_o.rd_last) streaming_q <= 1'b0;
      end
    end
  end

  // Payload registers of the request and results.
  logic [BW-1:0] wr_off;
  assign wr_off = alen_q[BW-1:0];
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      key_q <= nkey;
      nlen_q <= nlen;
      id_q <= chan_sel_i;
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
      snd_q <= (sender_id_i != '0) ? sender_id_i : task_now_i;
      cap_q <= receive_capacity_i;
    end
    // The head length is read while the scan state passes.
    head_len_q <= len_mem[rd_slot];
    // Bytes gather in the assembly buffer so that no queued slot is touched.
    if (cmd_i.send_exec && alen_q < LenW'(MessageBytes))
      asm_mem[wr_off] <= byte_q;
    if (cmd_i.send_exec && commit) begin
      len_mem[wr_slot] <= alen_n;
      snd_mem[wr_slot] <= snd_q;
      cp_slot_q <= wr_slot;
      cp_len_q <= alen_n;
      cp_rd_q <= '0;
    end
    // Copy pipeline: read one assembled byte, write it in the next cycle.
    if (cmd_i.copy_step) begin
      asm_rd_q <= asm_mem[cp_rd_q];
      cp_wr_q <= cp_rd_q;
      cp_rd_q <= cp_rd_q + 1'b1;
    end
    if (cp_wr_v_q) pay_mem[{cp_slot_q, cp_wr_q}] <= asm_rd_q;
    if (cmd_i.rd_start) begin
      rslot_sel_q <= rd_slot;
      rptr_q <= '0;
      len_rd_q <= len_mem[rd_slot];
      snd_rd_q <= snd_mem[rd_slot];
    end
    if (cmd_i.rd_step) rptr_q <= rptr_q + 1'b1;
    pay_rd_q <= pay_mem[{rslot_sel_q, (cmd_i.rd_step ? rptr_q + 1'b1 : rptr_q)}];
    if (emit_i) begin
      st_q <= streaming_q ? StOk : res_st;
      fc_q <= streaming_q ? 4'd0 : res_fc;
      out_byte_o <= streaming_q ? pay_rd_q : 8'd0;
      message_length_o <= streaming_q ? 7'(len_rd_q) : 7'd0;
      message_sender_o <= streaming_q ? snd_rd_q : 64'd0;
      open_count_o <= 5'(do_create ? total_q + 1'b1 : total_q);
    end
  end

  assign status_o = st_q;
  assign found_channel_o = fc_q;
endmodule

// ----- bench/ncmm_checker.sv -----
// Checker of the named channel mailbox: watches both streams, predicts and compares.
`timescale 1ns / 1ps
module ncmm_checker import ncmm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [231:0] s_tdata_i,
  input  logic         s_tlast_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [95:0]  m_tdata_i,
  input  logic         m_tlast_i,
  output int           errors_o,
  output int           pending_o
);

  typedef struct packed {
    logic [2:0]      status;
    logic [3:0]      found;
    logic [7:0]      data;
    logic [LenW-1:0] length;
    logic [63:0]     sender;
    logic [4:0]      opened;
    logic            fin;
  } mbox_result_t;

  // Mirror of the mailbox state.
  logic                  chan_open  [Channels];
  logic [63:0]           chan_name  [Channels];
  logic [QW-1:0]         head_slot  [Channels];
  logic [QW-1:0]         tail_slot  [Channels];
  int                    msg_count  [Channels];
  logic [7:0]            slot_bytes [Channels*QueueDepth][MessageBytes];
  int                    slot_len   [Channels*QueueDepth];
  logic [63:0]           slot_sender[Channels*QueueDepth];
  int                    open_total;
  int                    asm_len;
  logic                  asm_over;
  logic [7:0]            asm_bytes  [MessageBytes];

  mbox_result_t expected_results[$];
  int errors;

  assign errors_o  = errors;
  assign pending_o = expected_results.size();

  task automatic report(input string what, input logic [95:0] got, input logic [95:0] want);
    $display("%0t mismatch in %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic add_result(input logic [2:0] st, input int ch, input logic [7:0] b,
                            input int len, input logic [63:0] snd, input logic fin);
    mbox_result_t r;
    r.status = st; r.found = ch[3:0]; r.data = b; r.length = len[LenW-1:0];
    r.sender = snd; r.opened = open_total[4:0]; r.fin = fin;
    expected_results.push_back(r);
  endtask

  // Work out the results of one accepted request and update the mirror.
  task automatic predict_request(input logic [231:0] d, input logic last);
    logic [2:0]  mode;
    logic [63:0] raw, name, snd;
    logic [7:0]  id, c;
    logic [15:0] cap;
    int nlen, ch, slot;
    mode = d[2:0]; raw = d[66:3]; id = d[74:67]; cap = d[226:211];
    snd = (d[146:83] != 0) ? d[146:83] : d[210:147];
    name = '0; nlen = 0;
    for (int i = 0; i < NameChars; i++) begin
      c = raw[8*i +: 8];
      if (c == 0) break;
      name[8*i +: 8] = c;
      nlen++;
    end
    ch = -1;
    if (nlen != 0)
      for (int i = 0; i < Channels; i++)
        if (ch < 0 && chan_open[i] && chan_name[i] == name) ch = i;
    case (mode)
      ModeCreate: begin
        if (nlen == 0) begin
          add_result(StBadArg, 0, 0, 0, 0, 1);
        end else begin
          if (ch < 0)
            for (int i = 0; i < Channels; i++)
              if (ch < 0 && !chan_open[i]) ch = i;
          if (ch < 0) begin
            add_result(StNoSlot, 0, 0, 0, 0, 1);
          end else begin
            if (!(chan_open[ch] && chan_name[ch] == name)) begin
              chan_open[ch] = 1; chan_name[ch] = name;
              head_slot[ch] = 0; tail_slot[ch] = 0; msg_count[ch] = 0;
              open_total++;
            end
            add_result(StOk, ch, 0, 0, 0, 1);
          end
        end
      end
      ModeFind: begin
        if (ch < 0) add_result(StNotFound, 0, 0, 0, 0, 1);
        else add_result(StOk, ch, 0, 0, 0, 1);
      end
      ModeSend: begin
        logic [2:0] st;
        st = StOk;
        if (asm_len < MessageBytes) begin
          asm_bytes[asm_len] = d[82:75];
          asm_len++;
        end else begin
          asm_over = 1;
        end
        if (last) begin
          if (asm_over) st = StBadArg;
          else if (id >= Channels || !chan_open[id]) st = StBadChan;
          else if (msg_count[id] >= QueueDepth) st = StFull;
          else begin
            slot = id * QueueDepth + tail_slot[id];
            for (int i = 0; i < asm_len; i++) slot_bytes[slot][i] = asm_bytes[i];
            slot_len[slot] = asm_len;
            slot_sender[slot] = snd;
            tail_slot[id]++;
            msg_count[id]++;
          end
          asm_len = 0; asm_over = 0;
        end
        add_result(st, 0, 0, 0, 0, 1);
      end
      ModeRecv: begin
        if (id >= Channels || !chan_open[id]) begin
          add_result(StBadChan, 0, 0, 0, 0, 1);
        end else if (msg_count[id] == 0) begin
          add_result(StEmpty, 0, 0, 0, 0, 1);
        end else begin
          slot = id * QueueDepth + head_slot[id];
          if (cap < slot_len[slot]) begin
            add_result(StSmall, 0, 0, 0, 0, 1);
          end else begin
            head_slot[id]++;
            msg_count[id]--;
            for (int i = 0; i < slot_len[slot]; i++)
              add_result(StOk, 0, slot_bytes[slot][i], slot_len[slot], slot_sender[slot],
                         i + 1 == slot_len[slot]);
          end
        end
      end
      ModeCount: add_result(StOk, 0, 0, 0, 0, 1);
      default: add_result(StBadArg, 0, 0, 0, 0, 1);
    endcase
  endtask

  // Compare delivered results, then predict from accepted requests.
  always @(posedge clk_i or negedge rst_ni) begin
    mbox_result_t w;
    if (!rst_ni) begin
      for (int i = 0; i < Channels; i++) begin
        chan_open[i] = 0; chan_name[i] = '0; head_slot[i] = '0; tail_slot[i] = '0;
        msg_count[i] = 0;
      end
      open_total = 0; asm_len = 0; asm_over = 0; errors = 0;
      expected_results.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", m_tdata_i, '0);
        end else begin
          w = expected_results.pop_front();
          if (m_tdata_i[2:0] !== w.status)
            report("status", 96'(m_tdata_i[2:0]), 96'(w.status));
          if (m_tdata_i[6:3] !== w.found)
            report("found_channel", 96'(m_tdata_i[6:3]), 96'(w.found));
          if (m_tdata_i[14:7] !== w.data)
            report("out_byte", 96'(m_tdata_i[14:7]), 96'(w.data));
          if (m_tdata_i[21:15] !== w.length)
            report("message_length", 96'(m_tdata_i[21:15]), 96'(w.length));
          if (m_tdata_i[85:22] !== w.sender)
            report("message_sender", 96'(m_tdata_i[85:22]), 96'(w.sender));
          if (m_tdata_i[90:86] !== w.opened)
            report("open_count", 96'(m_tdata_i[90:86]), 96'(w.opened));
          if (m_tdata_i[95:91] !== '0) report("zero fill", 96'(m_tdata_i[95:91]), '0);
          if (m_tlast_i !== w.fin) report("final_result", 96'(m_tlast_i), 96'(w.fin));
        end
      end
      if (s_tvalid_i && s_tready_i) predict_request(s_tdata_i, s_tlast_i);
    end
  end

endmodule

// ----- bench/testbench.sv -----
// Stimulus and verdict for the named channel mailbox.
`timescale 1ns / 1ps
module testbench import ncmm_pkg::*;;

  localparam int CycleLimit = 1000000;
  localparam int ItemGoal   = 310;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [231:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [95:0]  m_axis_tdata;
  logic         m_axis_tlast;
  int           errors, pending;
  int           cycles = 0;
  int           items = 0;
  logic         sender_steady = 0;
  logic         hold_request = 0;
  logic         holding = 0;
  logic [63:0]  names[20];

  always #5 clk_i = ~clk_i;

  named_channel_message_mailbox i_dut (.*);

  ncmm_checker i_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tlast_i(s_axis_tlast),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tlast_i(m_axis_tlast),
    .errors_o(errors), .pending_o(pending)
  );

  // Cycle count and timeout.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, a quiet window in every period, and one long hold-off.
  always @(posedge clk_i) begin
    if (holding) m_axis_tready <= 0;
    else if ((cycles % 3000) < 500) m_axis_tready <= 1;
    else m_axis_tready <= ($urandom_range(0, 99) >= 18);
  end

  initial begin
    wait (hold_request);
    holding = 1;
    repeat (400) @(posedge clk_i);
    holding = 0;
  end

  // Offer one request and wait for its acceptance.
  task automatic put_request(input logic [2:0] mode, input logic [63:0] key,
                             input logic [7:0] id, input logic [7:0] b, input logic last,
                             input logic [63:0] snd, input logic [63:0] cur,
                             input logic [15:0] cap);
    while (!sender_steady && $urandom_range(0, 99) < 18) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {5'd0, cap, cur, snd, b, id, key, mode};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    items++;
  endtask

  task automatic send_message(input logic [7:0] id, input int n, input logic [63:0] snd);
    for (int i = 0; i < n; i++) begin
      // Occasionally slip another request into an assembly in progress.
      if (i > 0 && $urandom_range(0, 29) == 0)
        put_request(ModeCount, {$urandom, $urandom}, id, 8'($urandom), 1'($urandom),
                    {$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom));
      put_request(ModeSend, {$urandom, $urandom}, id, 8'($urandom), i == n - 1, snd,
                  {$urandom, $urandom}, 16'($urandom));
    end
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] random_name();
    logic [63:0] k;
    k = '0;
    for (int i = 0; i < $urandom_range(1, NameChars); i++)
      k[8*i +: 8] = 8'($urandom_range(1, 255));
    return k;
  endfunction

  initial begin
    logic [63:0] cur;
    logic [7:0]  id;
    int pick, n;
    cur = {$urandom, $urandom};
    for (int i = 0; i < 20; i++) names[i] = random_name();
    names[0] = 64'h0000_0000_0041_4243;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed requests: every mode, name corner cases, error statuses.
    put_request(ModeCount, '0, '0, '0, 0, '0, '0, '0);
    put_request(ModeCreate, '0, '0, '0, 0, '0, '0, '0);
    put_request(ModeCreate, names[0], '0, '0, 0, '0, '0, '0);
    put_request(ModeCreate, 64'hAB00_0000_0041_4243, '0, '0, 0, '0, '0, '0);
    put_request(ModeCreate, '1, '0, '0, 0, '0, '0, '0);
    put_request(ModeFind, names[0], '0, '0, 0, '0, '0, '0);
    put_request(ModeFind, 64'h0000_0000_0000_0051, '0, '0, 0, '0, '0, '0);
    put_request(ModeFind, '0, '0, '0, 0, '0, '0, '0);
    put_request(ModeSend, '0, 8'd200, 8'h00, 1, '0, cur, '0);
    put_request(ModeSend, '0, 8'd5, 8'h11, 1, '0, cur, '0);
    put_request(ModeSend, '0, 8'd0, 8'h00, 0, '0, cur, '0);
    put_request(ModeSend, '0, 8'd0, 8'h5A, 0, '0, cur, '0);
    put_request(ModeSend, '0, 8'd0, 8'hA5, 1, '0, cur, '0);
    put_request(ModeSend, '0, 8'd0, 8'hFF, 1, '1, cur, '1);
    put_request(ModeRecv, '0, 8'd0, '0, 0, '0, cur, 16'd2);
    put_request(ModeRecv, '0, 8'd0, '0, 0, '0, cur, 16'd3);
    put_request(ModeRecv, '0, 8'd0, '0, 0, '0, cur, '1);
    put_request(ModeRecv, '0, 8'd0, '0, 0, '0, cur, '1);
    put_request(ModeRecv, '0, 8'd255, '0, 0, '0, cur, '1);
    for (int m = ModeCount + 1; m <= 3'b111; m++)
      put_request(3'(m), '1, '1, '1, 1, '1, '1, '1);
    drain();

    // Random part: mostly creates of a shared name pool, messages and receives.
    hold_request = 1;
    while (items < ItemGoal) begin
      sender_steady = (items > 120 && items < 180);
      if (items > 220 && items < 230) drain();
      if ($urandom_range(0, 49) == 0) cur = {$urandom, $urandom};
      id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, Channels - 1));
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        put_request(ModeCreate, names[$urandom_range(0, 19)], 8'($urandom), 8'($urandom),
                    1'($urandom), {$urandom, $urandom}, cur, 16'($urandom));
      end else if (pick < 23) begin
        put_request(ModeFind, ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
                    : names[$urandom_range(0, 19)], 8'($urandom), 8'($urandom),
                    1'($urandom), {$urandom, $urandom}, cur, 16'($urandom));
      end else if (pick < 55) begin
        n = ($urandom_range(0, 39) == 0) ? $urandom_range(MessageBytes - 1, MessageBytes + 2)
            : $urandom_range(1, 6);
        send_message(id, n, ($urandom_range(0, 2) == 0) ? '0 : {$urandom, $urandom});
      end else if (pick < 58) begin
        // Fill one queue to the brim and past it.
        for (int i = 0; i <= QueueDepth; i++) send_message(id, 1, {$urandom, $urandom});
      end else if (pick < 90) begin
        put_request(ModeRecv, {$urandom, $urandom}, id, 8'($urandom), 1'($urandom),
                    {$urandom, $urandom}, cur,
                    ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 70)));
      end else if (pick < 96) begin
        put_request(ModeCount, {$urandom, $urandom}, 8'($urandom), 8'($urandom),
                    1'($urandom), {$urandom, $urandom}, cur, 16'($urandom));
      end else begin
        put_request(3'($urandom_range(ModeCount + 1, 3'b111)), {$urandom, $urandom},
                    8'($urandom), 8'($urandom), 1'($urandom), {$urandom, $urandom}, cur,
                    16'($urandom));
      end
    end

    // Let every expected result arrive, then a short tail.
    drain();
    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule

// ----- named_channel_message_mailbox.f -----
src/ncmm_pkg.sv
src/ncmm_ctrl.sv
src/ncmm_datapath.sv
src/named_channel_message_mailbox.sv
bench/ncmm_checker.sv
bench/testbench.sv
